// ----- design/joystick_scale_trim_calibrate_macros.svh -----
// Assertion macros for the joystick conditioning block.
// Used by the top level only; needs nothing else.
`ifndef JOYSTICK_SCALE_TRIM_CALIBRATE_MACROS_SVH
`define JOYSTICK_SCALE_TRIM_CALIBRATE_MACROS_SVH

// same-cycle implication
`define JSTC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define JSTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/jstc_pkg.sv -----
// Package for the joystick conditioning block: widths, key codes, lane control.
// No dependencies; imported by jstc_lane and the top level.
`timescale 1ns / 1ps

package jstc_pkg;

  localparam int NUM_LANES = 4;
  localparam int RAW_W     = 12;
  localparam int OUT_W     = 10;
  localparam int KEY_W     = 4;
  localparam int STEP_W    = 8;
  localparam int BIAS_W    = 12;
  localparam int SUM_W     = 18;
  localparam int CNT_W     = 7;
  localparam int SCALED_W  = RAW_W + OUT_W;

  localparam int FULL_SCALE = 1000;
  localparam int CENTRE     = 500;
  localparam int RAW_MAX    = (1 << RAW_W) - 1;

  localparam int CAL_SAMPLES = 100;
  localparam int CAL_SHIFT   = 26;
  localparam int RECIP_W     = CAL_SHIFT + 1;
  localparam longint CAL_RECIP =
    ((longint'(1) << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;

  localparam int IN_TDATA_W  = ((NUM_LANES * RAW_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_LANES * OUT_W + 2 + 7) / 8) * 8;

  localparam int LANE_THROTTLE = 0;
  localparam int LANE_PITCH    = 1;
  localparam int LANE_ROLL     = 2;
  localparam int LANE_YAW      = 3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_KEY    = 1'b1;

  localparam logic [KEY_W-1:0] KEY_LEFT       = 4'd1;
  localparam logic [KEY_W-1:0] KEY_RIGHT      = 4'd2;
  localparam logic [KEY_W-1:0] KEY_UP         = 4'd3;
  localparam logic [KEY_W-1:0] KEY_DOWN       = 4'd4;
  localparam logic [KEY_W-1:0] KEY_LEFT_TOP   = 4'd5;
  localparam logic [KEY_W-1:0] KEY_RIGHT_TOP  = 4'd6;
  localparam logic [KEY_W-1:0] KEY_RIGHT_LONG = 4'd8;

  typedef struct packed {
    logic load;
    logic clear;
    logic trim_add;
    logic trim_sub;
    logic accum;
    logic fin_mult;
    logic fin_write;
  } lane_ctrl_t;

endpackage

// ----- design/jstc_lane.sv -----
// One channel lane: scaling stage, bias and calibration sum, output clamp.
// Depends on jstc_pkg; instantiated four times by the top level.
`timescale 1ns / 1ps

module jstc_lane
  import jstc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [RAW_W-1:0]         raw,
  input  logic                     centred,
  input  logic [STEP_W-1:0]        trim_step,
  input  lane_ctrl_t               ctrl,
  output logic [OUT_W-1:0]         value
);

  logic [SCALED_W-1:0]        prod_num;
  logic [OUT_W-1:0]           q_hi;
  logic [RAW_W:0]             rem;
  logic [OUT_W-1:0]           q_div;
  logic [OUT_W-1:0]           scaled;
  logic [OUT_W-1:0]           v_s1;
  logic signed [BIAS_W-1:0]   bias;
  logic signed [SUM_W-1:0]    sum;
  logic signed [OUT_W:0]      delta;
  logic [SUM_W-1:0]           mag;
  logic [SUM_W+RECIP_W-1:0]   prod;
  logic                       prod_neg;
  logic [OUT_W:0]             quot;
  logic signed [BIAS_W-1:0]   bias_cal;
  logic signed [BIAS_W:0]     trimmed;
  logic signed [BIAS_W-1:0]   bias_trim;
  logic signed [BIAS_W:0]     diff;

  // divide by 2^n - 1: shift, then one correction
  assign prod_num = SCALED_W'(raw) * SCALED_W'(FULL_SCALE);
  assign q_hi     = prod_num[SCALED_W-1:RAW_W];
  assign rem      = (RAW_W+1)'(prod_num[RAW_W-1:0]) + (RAW_W+1)'(q_hi);
  assign q_div    = (rem >= (RAW_W+1)'(RAW_MAX)) ? q_hi + OUT_W'(1) : q_hi;
  assign scaled   = OUT_W'(FULL_SCALE) - q_div;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v_s1 <= scaled;
    end
  end

  assign delta = centred ? $signed({1'b0, v_s1}) - (OUT_W+1)'(CENTRE)
                         : $signed({1'b0, v_s1});

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (ctrl.fin_mult) begin
      prod     <= (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(CAL_RECIP);
      prod_neg <= sum[SUM_W-1];
    end
  end

  assign quot     = prod[CAL_SHIFT +: (OUT_W+1)];
  assign bias_cal = prod_neg ? -$signed(BIAS_W'(quot)) : $signed(BIAS_W'(quot));

  always_comb begin
    if (ctrl.trim_add) begin
      trimmed = (BIAS_W+1)'(bias) + $signed((BIAS_W+1)'(trim_step));
    end else begin
      trimmed = (BIAS_W+1)'(bias) - $signed((BIAS_W+1)'(trim_step));
    end
    if (trimmed > (BIAS_W+1)'((1 << (BIAS_W-1)) - 1)) begin
      bias_trim = BIAS_W'((1 << (BIAS_W-1)) - 1);
    end else if (trimmed < -$signed((BIAS_W+1)'(1 << (BIAS_W-1)))) begin
      bias_trim = BIAS_W'(1 << (BIAS_W-1));
    end else begin
      bias_trim = trimmed[BIAS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
      sum  <= '0;
    end else begin
      priority if (ctrl.clear) begin
        bias <= '0;
        sum  <= '0;
      end else if (ctrl.fin_write) begin
        bias <= bias_cal;
        sum  <= '0;
      end else if (ctrl.trim_add || ctrl.trim_sub) begin
        bias <= bias_trim;
      end else if (ctrl.accum) begin
        sum <= sum + SUM_W'(delta);
      end
    end
  end

  assign diff = $signed((BIAS_W+1)'(v_s1)) - (BIAS_W+1)'(bias);

  always_comb begin
    if (diff < 0) begin
      value = '0;
    end else if (diff > (BIAS_W+1)'(FULL_SCALE)) begin
      value = OUT_W'(FULL_SCALE);
    end else begin
      value = diff[OUT_W-1:0];
    end
  end

endmodule

// ----- design/joystick_scale_trim_calibrate.sv -----
// Joystick conditioning top: input stage, key decode, calibration control, output register.
// A stick sample is registered in the input stage, its result in the output register.
// Throughput: one request per cycle while results are taken; the last calibration sample
// holds the pipe in FIN_MULT and FIN_WRITE as each lane's reciprocal multiply sets its bias.
// Reset (rst, synchronous, active high) clears biases, sums, flags and sets trim_step to 10.
`timescale 1ns / 1ps

module joystick_scale_trim_calibrate
  import jstc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [STEP_W-1:0]      cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // raw_throttle, raw_pitch, raw_roll, raw_yaw, key_code, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [0:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // throttle_out, pitch_out, roll_out, yaw_out, power_off, fix_height, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

`include "joystick_scale_trim_calibrate_macros.svh"

  localparam logic [1:0] FIN_IDLE  = 2'd0;
  localparam logic [1:0] FIN_MULT  = 2'd1;
  localparam logic [1:0] FIN_WRITE = 2'd2;

  logic [STEP_W-1:0] trim_step;
  logic              s1_valid;
  logic              s1_op;
  logic [KEY_W-1:0]  s1_key;
  logic [1:0]        fin;
  logic [1:0]        fin_next;
  logic              calibrating;
  logic [CNT_W-1:0]  cal_count;
  logic [CNT_W-1:0]  count_inc;
  logic              cal_done;
  logic              power_off_flag;
  logic              hold_height_flag;
  logic              produce;
  logic              out_free;
  logic              s1_adv;
  logic              load;
  logic              sample_exec;
  logic              key_exec;
  lane_ctrl_t        lane_ctrl [NUM_LANES];
  logic [OUT_W-1:0]  lane_val  [NUM_LANES];

  assign produce       = (s1_op == OP_SAMPLE) && !calibrating;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && (fin == FIN_IDLE) && (!produce || out_free);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign sample_exec   = s1_adv && (s1_op == OP_SAMPLE);
  assign key_exec      = s1_adv && (s1_op == OP_KEY);
  assign count_inc     = cal_count + CNT_W'(1);
  assign cal_done      = count_inc >= CNT_W'(CAL_SAMPLES);

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_ctrl[i].load      = load;
      lane_ctrl[i].clear     = key_exec && (s1_key == KEY_RIGHT_LONG);
      lane_ctrl[i].trim_add  = 1'b0;
      lane_ctrl[i].trim_sub  = 1'b0;
      lane_ctrl[i].accum     = sample_exec && calibrating;
      lane_ctrl[i].fin_mult  = (fin == FIN_MULT);
      lane_ctrl[i].fin_write = (fin == FIN_WRITE);
    end
    lane_ctrl[LANE_ROLL].trim_add  = key_exec && (s1_key == KEY_LEFT);
    lane_ctrl[LANE_ROLL].trim_sub  = key_exec && (s1_key == KEY_RIGHT);
    lane_ctrl[LANE_PITCH].trim_add = key_exec && (s1_key == KEY_DOWN);
    lane_ctrl[LANE_PITCH].trim_sub = key_exec && (s1_key == KEY_UP);
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    jstc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .raw       (s_axis_tdata[g*RAW_W +: RAW_W]),
      .centred   (g != LANE_THROTTLE),
      .trim_step (trim_step),
      .ctrl      (lane_ctrl[g]),
      .value     (lane_val[g])
    );
  end

  always_comb begin
    fin_next = fin;
    unique case (fin)
      FIN_IDLE: begin
        if (sample_exec && calibrating && cal_done) begin
          fin_next = FIN_MULT;
        end
      end
      FIN_MULT:  fin_next = FIN_WRITE;
      FIN_WRITE: fin_next = FIN_IDLE;
      default:   fin_next = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_step        <= STEP_W'(10);
      s1_valid         <= 1'b0;
      fin              <= FIN_IDLE;
      calibrating      <= 1'b0;
      cal_count        <= '0;
      power_off_flag   <= 1'b0;
      hold_height_flag <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        trim_step <= cfg_wdata;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      fin <= fin_next;
      if (key_exec && (s1_key == KEY_LEFT_TOP)) begin
        power_off_flag <= 1'b1;
      end
      if (key_exec && (s1_key == KEY_RIGHT_TOP)) begin
        hold_height_flag <= 1'b1;
      end
      if (key_exec && (s1_key == KEY_RIGHT_LONG)) begin
        calibrating <= 1'b1;
        cal_count   <= '0;
      end else if (sample_exec && calibrating) begin
        cal_count <= cal_done ? '0 : count_inc;
      end else if (fin == FIN_WRITE) begin
        calibrating <= 1'b0;
      end
      if (sample_exec && produce) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op  <= s_axis_tuser[0];
      s1_key <= s_axis_tdata[NUM_LANES*RAW_W +: KEY_W];
    end
    if (sample_exec && produce) begin
      m_axis_tdata <= OUT_TDATA_W'({hold_height_flag, power_off_flag,
                                    lane_val[LANE_YAW], lane_val[LANE_ROLL],
                                    lane_val[LANE_PITCH], lane_val[LANE_THROTTLE]});
    end
  end

  `JSTC_ASSERT_IMP(a_no_exec_in_finish, clk, rst, fin != FIN_IDLE, !s1_adv)
  `JSTC_ASSERT_NEXT(a_mult_then_write, clk, rst, fin == FIN_MULT, fin == FIN_WRITE)
  `JSTC_ASSERT_NEXT(a_result_follows, clk, rst, sample_exec && !calibrating, m_axis_tvalid)
  `JSTC_ASSERT_IMP(a_count_idle, clk, rst, !calibrating, cal_count == '0)

endmodule

// ----- tb/sv/joystick_scale_trim_calibrate_checker.sv -----
// Checker for the joystick conditioning block: watches the request, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on jstc_pkg for widths, key codes and lane indexes.
`timescale 1ns / 1ps

module joystick_scale_trim_calibrate_checker
  import jstc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [STEP_W-1:0]      cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     errors,
  output int                     outstanding,
  output int                     compared
);

  localparam int TRIM_STEP_RESET = 10;
  localparam int BIAS_LOW        = -(1 << (BIAS_W - 1));
  localparam int BIAS_HIGH       = (1 << (BIAS_W - 1)) - 1;

  typedef struct packed {
    logic                            fix_height;
    logic                            power_off;
    logic [NUM_LANES-1:0][OUT_W-1:0] lane;
  } stick_frame_t;

  string lane_label [NUM_LANES] = '{"throttle_out", "pitch_out", "roll_out", "yaw_out"};

  logic [STEP_W-1:0]       step_size;
  logic signed [BIAS_W-1:0] bias [NUM_LANES];
  logic signed [SUM_W-1:0]  cal_sum [NUM_LANES];
  logic [CNT_W-1:0]        cal_taken;
  logic                    cal_active;
  logic                    power_off_set;
  logic                    hold_height_set;
  stick_frame_t            frames_due [$];
  int                      mismatches = 0;
  int                      frames_compared = 0;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int scaled(logic [RAW_W-1:0] x);
    return FULL_SCALE - (int'(x) * FULL_SCALE) / RAW_MAX;
  endfunction

  function automatic void nudge_bias(int lane, int delta);
    bias[lane] = BIAS_W'(clip(int'(bias[lane]) + delta, BIAS_LOW, BIAS_HIGH));
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < NUM_LANES; i++) begin
      bias[i] = '0;
      cal_sum[i] = '0;
    end
    cal_taken = '0;
  endfunction

  function automatic void apply_request(logic op, logic [IN_TDATA_W-1:0] data);
    int v [NUM_LANES];
    stick_frame_t f;
    if (op == OP_KEY) begin
      case (data[NUM_LANES*RAW_W +: KEY_W])
        KEY_LEFT:       nudge_bias(LANE_ROLL, int'(step_size));
        KEY_RIGHT:      nudge_bias(LANE_ROLL, -int'(step_size));
        KEY_UP:         nudge_bias(LANE_PITCH, -int'(step_size));
        KEY_DOWN:       nudge_bias(LANE_PITCH, int'(step_size));
        KEY_LEFT_TOP:   power_off_set = 1'b1;
        KEY_RIGHT_TOP:  hold_height_set = 1'b1;
        KEY_RIGHT_LONG: begin
          clear_history();
          cal_active = 1'b1;
        end
        default: ;
      endcase
      return;
    end
    for (int i = 0; i < NUM_LANES; i++) v[i] = scaled(data[i*RAW_W +: RAW_W]);
    if (cal_active) begin
      for (int i = 0; i < NUM_LANES; i++)
        cal_sum[i] = SUM_W'(int'(cal_sum[i]) + v[i] - (i == LANE_THROTTLE ? 0 : CENTRE));
      cal_taken = cal_taken + 1'b1;
      if (cal_taken >= CAL_SAMPLES) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          bias[i] = BIAS_W'(clip(int'(cal_sum[i]) / CAL_SAMPLES, BIAS_LOW, BIAS_HIGH));
          cal_sum[i] = '0;
        end
        cal_taken = '0;
        cal_active = 1'b0;
      end
      return;
    end
    for (int i = 0; i < NUM_LANES; i++)
      f.lane[i] = OUT_W'(clip(v[i] - int'(bias[i]), 0, FULL_SCALE));
    f.power_off = power_off_set;
    f.fix_height = hold_height_set;
    frames_due.push_back(f);
  endfunction

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    stick_frame_t got;
    stick_frame_t want;
    if (rst) begin
      step_size = STEP_W'(TRIM_STEP_RESET);
      clear_history();
      cal_active = 1'b0;
      power_off_set = 1'b0;
      hold_height_set = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_we) step_size = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(stick_frame_t)-1:0];
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          frames_compared++;
          for (int i = 0; i < NUM_LANES; i++)
            compare_field(lane_label[i], want.lane[i], got.lane[i]);
          compare_field("power_off", want.power_off, got.power_off);
          compare_field("fix_height", want.fix_height, got.fix_height);
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser[0], s_axis_tdata);
    end
    outstanding <= frames_due.size();
    errors <= mismatches;
    compared <= frames_compared;
  end

endmodule

// ----- tb/sv/joystick_scale_trim_calibrate_test.sv -----
// Top of the joystick conditioning testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Needs jstc_pkg, the block and
// joystick_scale_trim_calibrate_checker.
`timescale 1ns / 1ps

module joystick_scale_trim_calibrate_test;
  import jstc_pkg::*;

  localparam int STICK_W       = NUM_LANES * RAW_W;
  localparam int KEY_CODE_MAX  = (1 << KEY_W) - 1;
  localparam int STEP_MAX      = (1 << STEP_W) - 1;
  localparam int ITEM_TARGET   = 900;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CAL_JITTER    = 60;
  localparam int TIMEOUT_NS    = 2_000_000;

  localparam logic [KEY_W-1:0] KEY_NONE      = 4'd0;
  localparam logic [KEY_W-1:0] KEY_LEFT_LONG = 4'd7;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [STEP_W-1:0]      cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int errors;
  int outstanding;
  int compared;

  int burst_left = 0;
  int counted = 0;
  int samples_sent = 0;
  int keys_sent = 0;
  int calibrations = 0;
  int step_writes = 0;
  logic [9:0] ready_phase = '0;

  joystick_scale_trim_calibrate dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  joystick_scale_trim_calibrate_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .outstanding   (outstanding),
    .compared      (compared)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // hold results back on a pattern chosen by the top bits of ready_phase
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    case (ready_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (ready_phase[3:0] < 4'd11);
    endcase
  end

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RAW_W'(RAW_MAX);
      2:       return RAW_W'((RAW_MAX + 1) / 2 + int'($urandom_range(0, 80)) - 40);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [STICK_W-1:0] random_stick();
    logic [STICK_W-1:0] s;
    for (int i = 0; i < NUM_LANES; i++) s[i*RAW_W +: RAW_W] = random_raw();
    return s;
  endfunction

  function automatic logic [STICK_W-1:0] stick_of(logic [RAW_W-1:0] thr, logic [RAW_W-1:0] pit,
                                                   logic [RAW_W-1:0] rol, logic [RAW_W-1:0] yw);
    return {yw, rol, pit, thr};
  endfunction

  function automatic logic [KEY_W-1:0] random_arrow();
    case ($urandom_range(0, 3))
      0:       return KEY_LEFT;
      1:       return KEY_RIGHT;
      2:       return KEY_UP;
      default: return KEY_DOWN;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] key_but_long();
    case ($urandom_range(0, 7))
      0:       return KEY_NONE;
      1:       return KEY_LEFT_LONG;
      2:       return KEY_LEFT_TOP;
      3:       return KEY_RIGHT_TOP;
      default: return random_arrow();
    endcase
  endfunction

  task automatic push_request(input logic op, input logic [STICK_W-1:0] stick,
                              input logic [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - STICK_W - KEY_W){1'b0}}, key, stick};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_SAMPLE) begin
      samples_sent++;
      counted++;
    end else begin
      keys_sent++;
      case (key)
        KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN, KEY_LEFT_TOP, KEY_RIGHT_TOP, KEY_RIGHT_LONG:
          counted++;
        default: ;
      endcase
    end
  endtask

  task automatic push_sample(input logic [STICK_W-1:0] stick);
    push_request(OP_SAMPLE, stick, KEY_W'($urandom_range(0, KEY_CODE_MAX)));
  endtask

  task automatic push_key(input logic [KEY_W-1:0] key);
    push_request(OP_KEY, random_stick(), key);
  endtask

  // drain, let the pipe settle, then write the next trim step
  task automatic settle_and_write();
    logic [STEP_W-1:0] value;
    case (step_writes)
      0:       value = STEP_W'(STEP_MAX);
      1:       value = '0;
      2:       value = 8'd1;
      default: value = STEP_W'($urandom_range(0, STEP_MAX));
    endcase
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_writes++;
  endtask

  task automatic arrow_storm(input logic [KEY_W-1:0] favoured, input int presses);
    repeat (presses) begin
      if ($urandom_range(0, 4) == 0) push_sample(random_stick());
      else if ($urandom_range(0, 9) < 7) push_key(favoured);
      else push_key(random_arrow());
    end
  endtask

  task automatic run_calibration(input logic with_keys);
    logic [RAW_W-1:0] base [NUM_LANES];
    logic [STICK_W-1:0] stick;
    int taken;
    int restart_at;
    int jitter;
    for (int i = 0; i < NUM_LANES; i++) base[i] = random_raw();
    restart_at = with_keys ? $urandom_range(5, CAL_SAMPLES - 5) : -1;
    push_key(KEY_RIGHT_LONG);
    taken = 0;
    while (taken < CAL_SAMPLES) begin
      if (taken == restart_at) begin
        push_key(KEY_RIGHT_LONG);
        taken = 0;
        restart_at = -1;
      end else if (with_keys && $urandom_range(0, 9) == 0) begin
        push_key(key_but_long());
      end else begin
        for (int i = 0; i < NUM_LANES; i++) begin
          jitter = int'(base[i]) + int'($urandom_range(0, 2 * CAL_JITTER)) - CAL_JITTER;
          jitter = (jitter < 0) ? 0 : (jitter > RAW_MAX) ? RAW_MAX : jitter;
          stick[i*RAW_W +: RAW_W] = RAW_W'(jitter);
        end
        push_sample(stick);
        taken++;
      end
    end
    calibrations++;
  endtask

  task automatic noise_burst(input int count);
    logic [KEY_W-1:0] key;
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) begin
        push_sample(random_stick());
      end else begin
        if ($urandom_range(0, 2) == 0)
          key = KEY_W'($urandom_range(int'(KEY_RIGHT_LONG) + 1, KEY_CODE_MAX));
        else
          key = key_but_long();
        push_key(key);
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_sample(stick_of('0, '0, '0, '0));
    push_sample(stick_of(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), RAW_W'(RAW_MAX)));
    push_sample(stick_of(RAW_W'((RAW_MAX + 1) / 2), RAW_W'((RAW_MAX + 1) / 2),
                         RAW_W'((RAW_MAX + 1) / 2), RAW_W'((RAW_MAX + 1) / 2)));
    push_sample(stick_of(12'hAAA, 12'h555, 12'h555, 12'hAAA));
    push_sample(stick_of('0, RAW_W'(RAW_MAX), RAW_W'(1), RAW_W'(RAW_MAX - 1)));
    push_key(KEY_NONE);
    push_key(KEY_LEFT_LONG);
    push_key(KEY_W'(KEY_CODE_MAX));
    push_key(KEY_LEFT);
    push_key(KEY_DOWN);
    push_sample(stick_of('0, RAW_W'((RAW_MAX + 1) / 2), RAW_W'((RAW_MAX + 1) / 2), '0));
    push_key(KEY_RIGHT);
    push_key(KEY_RIGHT);
    push_key(KEY_UP);
    push_key(KEY_UP);
    push_sample(stick_of('0, RAW_W'((RAW_MAX + 1) / 2), RAW_W'((RAW_MAX + 1) / 2), '0));
    push_key(KEY_LEFT_TOP);
    push_sample(random_stick());
    push_key(KEY_RIGHT_TOP);
    push_sample(random_stick());

    // drive both trimmed biases into saturation at the widest step
    settle_and_write();
    arrow_storm(KEY_LEFT, 40);
    arrow_storm(KEY_UP, 40);
    arrow_storm(KEY_RIGHT, 60);
    arrow_storm(KEY_DOWN, 60);
    run_calibration(1'b1);

    while (counted < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0:       settle_and_write();
        1:       run_calibration(1'($urandom_range(0, 1)));
        2, 3:    arrow_storm(random_arrow(), $urandom_range(4, 30));
        4, 5:    noise_burst($urandom_range(5, 20));
        default: repeat ($urandom_range(5, 40)) push_sample(random_stick());
      endcase
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d stick samples and %0d key events over %0d calibrations and %0d trim steps,",
             samples_sent, keys_sent, calibrations, step_writes);
    $display("with %0d conditioned results checked field by field.", compared);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
